FILE: rtl/gic_pkg.sv
// Package for the grid island counter: grid geometry, widths and sequencer states.
// No dependencies; used by every module of the block.
`default_nettype none
package gic_pkg;
  localparam int GridDim   = 256;
  localparam int CoordW    = 8;
  localparam int CellW     = 16;
  localparam int CellTotal = GridDim * GridDim;
  localparam int SizeW     = 17;
  localparam int CountW    = 17;
  localparam int ClearW    = CellW;

  typedef logic [CellW-1:0] cell_t;
  typedef logic [SizeW-1:0] size_t;

  // Memory port command from the sequencer to the store.
  typedef struct packed {
    logic  rd_en;
    cell_t rd_addr;
    logic  wr_en;
    cell_t wr_addr;
    cell_t wr_parent;
    size_t wr_size;
  } mem_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_NBR,
    ST_NBR_RD,
    ST_FIND_A,
    ST_FIND_B,
    ST_JOIN,
    ST_DONE
  } seq_state_e;
endpackage
`default_nettype wire

FILE: rtl/gic_store.sv
// Cell store: parent link and set size per cell in one synchronous memory.
// Depends on gic_pkg. One read and one write port, read data registered.
`default_nettype none
module gic_store
  import gic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_cmd_t cmd_i,
  output logic [CellW+SizeW-1:0] rd_data_o
);
  logic [CellW+SizeW-1:0] mem [CellTotal];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= {cmd_i.wr_parent, cmd_i.wr_size};
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_o <= mem[cmd_i.rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gic_seq.sv
// Sequencer: insert, neighbor scan, root walks and union by size.
// Depends on gic_pkg; drives the command port of gic_store.
`default_nettype none
module gic_seq
  import gic_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [CoordW-1:0]      row_i,
  input  wire logic [CoordW-1:0]      col_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [CountW-1:0]           count_o,
  output logic                        flag_o,
  output mem_cmd_t                    cmd_o,
  input  wire logic [CellW+SizeW-1:0] rd_data_i
);
  seq_state_e state_q, state_d;
  logic [ClearW-1:0] clr_q, clr_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CoordW-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]        dir_q, dir_d;
  logic              flag_q, flag_d;
  cell_t             walk_q, walk_d, root_a_q, root_a_d;
  size_t             size_a_q, size_a_d;
  cell_t             nbr_cell;
  logic              nbr_ok;
  cell_t             home_cell;
  cell_t             rd_parent;
  size_t             rd_size;

  assign rd_parent = rd_data_i[CellW+SizeW-1:SizeW];
  assign rd_size   = rd_data_i[SizeW-1:0];
  assign home_cell = {row_q, col_q};

  // Neighbor of the current direction: up, right, down, left.
  always_comb begin
    nbr_ok   = 1'b1;
    nbr_cell = home_cell;
    case (dir_q)
      2'd0: begin
        nbr_ok = (row_q != '0);
        nbr_cell = {row_q - CoordW'(1), col_q};
      end
      2'd1: begin
        nbr_ok = (col_q != '1);
        nbr_cell = {row_q, col_q + CoordW'(1)};
      end
      2'd2: begin
        nbr_ok = (row_q != '1);
        nbr_cell = {row_q + CoordW'(1), col_q};
      end
      default: begin
        nbr_ok = (col_q != '0);
        nbr_cell = {row_q, col_q - CoordW'(1)};
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    dir_q    <= dir_d;
    flag_q   <= flag_d;
    walk_q   <= walk_d;
    root_a_q <= root_a_d;
    size_a_q <= size_a_d;
  end

  // Next state and memory commands.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    count_d  = count_q;
    row_d    = row_q;
    col_d    = col_q;
    dir_d    = dir_q;
    flag_d   = flag_q;
    walk_d   = walk_q;
    root_a_d = root_a_q;
    size_a_d = size_a_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    done_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = clr_q[CellW-1:0];
        clr_d = clr_q + ClearW'(1);
        if (clr_q[CellW-1:0] == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          row_d = row_i;
          col_d = col_i;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = {row_i, col_i};
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dir_d = 2'd0;
        if (rd_size != '0) begin
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          flag_d = 1'b0;
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_addr   = home_cell;
          cmd_o.wr_parent = home_cell;
          cmd_o.wr_size   = SizeW'(1);
          count_d = count_q + CountW'(1);
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        if (nbr_ok) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = nbr_cell;
          state_d = ST_NBR_RD;
        end else if (dir_q == 2'd3) begin
          state_d = ST_DONE;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      ST_NBR_RD: begin
        if (rd_size != '0) begin
          walk_d = home_cell;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = home_cell;
          state_d = ST_FIND_A;
        end else if (dir_q == 2'd3) begin
          state_d = ST_DONE;
        end else begin
          dir_d = dir_q + 2'd1;
          state_d = ST_NBR;
        end
      end
      // Walk from the new cell to its root.
      ST_FIND_A: begin
        if (rd_parent == walk_q) begin
          root_a_d = walk_q;
          size_a_d = rd_size;
          walk_d = nbr_cell;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = nbr_cell;
          state_d = ST_FIND_B;
        end else begin
          walk_d = rd_parent;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = rd_parent;
        end
      end
      // Walk from the neighbor to its root, then join if the roots differ.
      ST_FIND_B: begin
        if (rd_parent == walk_q) begin
          if (walk_q != root_a_q) begin
            count_d = count_q - CountW'(1);
            cmd_o.wr_en = 1'b1;
            if (size_a_q > rd_size) begin
              cmd_o.wr_addr   = walk_q;
              cmd_o.wr_parent = root_a_q;
              cmd_o.wr_size   = rd_size;
              root_a_d = walk_q;
              walk_d   = root_a_q;
              size_a_d = size_a_q + rd_size;
            end else begin
              cmd_o.wr_addr   = root_a_q;
              cmd_o.wr_parent = walk_q;
              cmd_o.wr_size   = size_a_q;
              size_a_d = size_a_q + rd_size;
            end
            state_d = ST_JOIN;
          end else if (dir_q == 2'd3) begin
            state_d = ST_DONE;
          end else begin
            dir_d = dir_q + 2'd1;
            state_d = ST_NBR;
          end
        end else begin
          walk_d = rd_parent;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = rd_parent;
        end
      end
      // Grow the surviving root's size.
      ST_JOIN: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_addr   = walk_q;
        cmd_o.wr_parent = walk_q;
        cmd_o.wr_size   = size_a_q;
        if (dir_q == 2'd3) begin
          state_d = ST_DONE;
        end else begin
          dir_d = dir_q + 2'd1;
          state_d = ST_NBR;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign count_o = count_q;
  assign flag_o  = flag_q;

  // A beat is presented only from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held two cycles");
  // After the check state the count holds or rises by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> (count_q == $past(count_q)) ||
                             (count_q == $past(count_q) + CountW'(1)))
    else $error("bad count step on insert");
  // No write while waiting for a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmd_o.wr_en)
    else $error("store written while idle");
endmodule
`default_nettype wire

FILE: rtl/grid_island_counter.sv
// Top level of the grid island counter: sequencer plus cell store.
// Depends on gic_pkg, gic_seq and gic_store.
// Sequence: a repeat cell goes from acceptance through the check state to the result strobe;
// a new cell also scans up to four neighbors, with two root walks for each land neighbor,
// and each root walk reads the single store port once per node, chain depth about log2 of set size.
// Reset: a clearing pass writes every cell to water; busy stays high until it ends.
// One item at a time. The receiver cannot stall: each result is strobed for one cycle.
`default_nettype none
module grid_island_counter
  import gic_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CoordW-1:0] cell_row_i,
  input  wire logic [CoordW-1:0] cell_col_i,
  output logic                   result_valid_o,
  output logic [CountW-1:0]      region_count_o,
  output logic                   already_land_o
);
  mem_cmd_t               cmd;
  logic [CellW+SizeW-1:0] rd_data;

  gic_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .row_i     (cell_row_i),
    .col_i     (cell_col_i),
    .busy_o    (busy),
    .done_o    (result_valid_o),
    .count_o   (region_count_o),
    .flag_o    (already_land_o),
    .cmd_o     (cmd),
    .rd_data_i (rd_data)
  );

  gic_store u_store (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );
endmodule
`default_nettype wire
